@@ rtl/core/rcnm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcnm_pkg
// Shared widths, register indexes and bit-grid helpers for the rotated code
// nearest-match block.
// ----------------------------------------------------------------------------
package rcnm_pkg;

	localparam int CODE_W          = 36;
	localparam int GRID_SIDE       = 6;
	localparam int DIST_W          = 6;
	localparam int ID_W            = 10;
	localparam int MH_W            = 6;
	localparam int CIU_W           = 11;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 11;
	localparam int ROT_N           = 4;
	localparam int ROT_W           = 2;
	localparam int TABLE_DEPTH_DEF = 1024;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_HAMMING  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CODES_IN_USE = 1'b1;

	localparam logic [MH_W-1:0]  MAX_HAMMING_RST  = 6'd1;
	localparam logic [CIU_W-1:0] CODES_IN_USE_RST = 11'd0;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [DIST_W-1:0] dist_t;

	// Turn the 6x6 grid a quarter clockwise: cell (row,col) goes to (col, 5-row)
	function automatic code_t turn_cw(input code_t v);
		code_t r;
		r = '0;
		for (int row = 0; row < GRID_SIDE; row++) begin
			for (int col = 0; col < GRID_SIDE; col++) begin
				r[col * GRID_SIDE + (GRID_SIDE - 1 - row)] = v[row * GRID_SIDE + col];
			end
		end
		return r;
	endfunction

	// Count set bits: per-row counts first, then sum the rows
	function automatic dist_t bit_count(input code_t v);
		logic [2:0] row_cnt [GRID_SIDE];
		dist_t      total;
		total = '0;
		for (int row = 0; row < GRID_SIDE; row++) begin
			row_cnt[row] = '0;
			for (int col = 0; col < GRID_SIDE; col++) begin
				row_cnt[row] = row_cnt[row] + {2'b00, v[row * GRID_SIDE + col]};
			end
		end
		for (int row = 0; row < GRID_SIDE; row++) begin
			total = total + {3'b000, row_cnt[row]};
		end
		return total;
	endfunction

endpackage

@@ rtl/core/rcnm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcnm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rcnm_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 1024,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/core/rotated_code_nearest_match.sv @@
`timescale 1ns / 1ps
// A query scans min(codes_in_use, TABLE_DEPTH) table entries through the table's
// single read port: one entry is read per cycle and compared against all four
// rotations at once.
// A load item writes the table in its acceptance cycle; the next item follows.
// No item is accepted while a query scans or waits for the output register.
// arst_n resets control and registers (max_hamming 1, codes_in_use 0), not the table.
// ----------------------------------------------------------------------------
// rotated_code_nearest_match
// Nearest table code search over the four quarter turns of a 6x6 bit grid.
// ----------------------------------------------------------------------------
module rotated_code_nearest_match #(
	parameter int TABLE_DEPTH = rcnm_pkg::TABLE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rcnm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rcnm_pkg::CFG_DATA_W-1:0] cfg_data,
	// Input items
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [47:0]                    s_tdata,  // entry_index[9:0], code_word[45:10]
	input  logic                           s_tuser,  // mode
	// Result items
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [23:0]                    m_tdata   // found[0], tag_id[10:1],
	                                                 // distance[16:11], rotation[18:17]
);

	import rcnm_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int DW = $clog2(TABLE_DEPTH + 1);
	localparam int LW = (DW > CIU_W) ? DW : CIU_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]       state_q;
	logic [MH_W-1:0]  max_hamming_q;
	logic [CIU_W-1:0] codes_in_use_q;

	logic             mode;
	logic [ID_W-1:0]  entry_index;
	code_t            code_word;
	logic             in_acc;

	code_t            code_q [ROT_N];
	logic [LW-1:0]    cnt_q;
	logic [LW-1:0]    lim_q;
	logic [LW-1:0]    lim;

	logic             rd_en;
	code_t            rd_data;
	logic             wr_en;
	logic             valid_s1;
	logic [AW-1:0]    idx_s1;
	logic             valid_s2;
	logic [AW-1:0]    idx_s2;
	dist_t            dist_s2 [ROT_N];

	logic [MH_W:0]    best_q    [ROT_N];
	logic [AW-1:0]    best_id_q [ROT_N];

	logic             sel_found;
	logic [ID_W-1:0]  sel_id;
	dist_t            sel_dist;
	logic [ROT_W-1:0] sel_rot;

	logic             out_free;
	logic             m_valid_q;
	logic [23:0]      m_data_q;

	// Unpack the input item
	assign mode        = s_tuser;
	assign entry_index = s_tdata[ID_W-1:0];
	assign code_word   = s_tdata[ID_W + CODE_W - 1:ID_W];

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign wr_en     = in_acc && !mode && (32'(entry_index) < TABLE_DEPTH);

	// Clamp the search length to the table depth
	assign lim = (LW'(codes_in_use_q) > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH)
	                                                       : LW'(codes_in_use_q);

	assign rd_en = (state_q == ST_SCAN) && (cnt_q < lim_q);

	rcnm_ram #(
		.WIDTH (CODE_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(entry_index)),
		.wr_data (code_word),
		.rd_en   (rd_en),
		.rd_addr (cnt_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_hamming_q  <= MAX_HAMMING_RST;
			codes_in_use_q <= CODES_IN_USE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MAX_HAMMING:  max_hamming_q  <= cfg_data[MH_W-1:0];
				REG_CODES_IN_USE: codes_in_use_q <= cfg_data[CIU_W-1:0];
				default:          ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			cnt_q    <= '0;
		end else begin
			valid_s1 <= rd_en;
			valid_s2 <= valid_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && mode) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (!valid_s1 && !valid_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Capture the query and its rotations, then track the best entry per rotation
	always_ff @(posedge clk) begin
		if (in_acc && mode) begin
			code_q[0] <= code_word;
			code_q[1] <= turn_cw(code_word);
			code_q[2] <= turn_cw(turn_cw(code_word));
			code_q[3] <= turn_cw(turn_cw(turn_cw(code_word)));
			lim_q     <= lim;
			for (int r = 0; r < ROT_N; r++) begin
				best_q[r]    <= {1'b0, max_hamming_q} + 1'b1;
				best_id_q[r] <= '0;
			end
		end else if (valid_s2) begin
			for (int r = 0; r < ROT_N; r++) begin
				if ({1'b0, dist_s2[r]} < best_q[r]) begin
					best_q[r]    <= {1'b0, dist_s2[r]};
					best_id_q[r] <= idx_s2;
				end
			end
		end
	end

	// Distance stage
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[AW-1:0];
		idx_s2 <= idx_s1;
		for (int r = 0; r < ROT_N; r++) begin
			dist_s2[r] <= bit_count(code_q[r] ^ rd_data);
		end
	end

	// Pick the lowest rotation that matched
	always_comb begin
		sel_found = 1'b0;
		sel_id    = '0;
		sel_dist  = '0;
		sel_rot   = '0;
		for (int r = ROT_N - 1; r >= 0; r--) begin
			if (best_q[r] <= {1'b0, max_hamming_q}) begin
				sel_found = 1'b1;
				sel_id    = ID_W'(best_id_q[r]);
				sel_dist  = best_q[r][DIST_W-1:0];
				sel_rot   = ROT_W'(r);
			end
		end
	end

	// Output register
	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_data_q <= {5'b00000, sel_rot, sel_dist, sel_id, sel_found};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

@@ rtl/core/rcnm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcnm_checker
// Port-level checks for the rotated code nearest-match block.
// ----------------------------------------------------------------------------
module rcnm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// Hold a stalled result item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	// No match means all result fields are zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[23:1] == 23'd0)
		else $error("miss result carries nonzero fields");

	// A match never exceeds the code width in distance
	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[16:11] <= 6'd36)
		else $error("match distance out of range");

	// Drop ready while a query scans
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> !s_tready)
		else $error("item accepted during a query scan");

endmodule

bind rotated_code_nearest_match rcnm_checker u_rcnm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ bench/match_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// match_checker
// Watches the configuration, input and result channels of the rotated code
// nearest-match block. Keeps its own copy of the code table and registers,
// works out the result of every accepted query and compares each result item
// field by field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module match_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [rcnm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rcnm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [47:0]                     s_tdata,  // entry_index[9:0], code_word[45:10]
	input  logic                            s_tuser,  // mode
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [23:0]                     m_tdata,  // found[0], tag_id[10:1],
	                                                  // distance[16:11], rotation[18:17]
	output int                              fail_count,
	output int                              pending
);
	import rcnm_pkg::*;

	localparam int   DEPTH      = TABLE_DEPTH_DEF;
	localparam logic MODE_QUERY = 1'b1;

	// Result fields, lowest bit first from the bottom of the declaration
	typedef struct packed {
		logic [ROT_W-1:0]  rotation;
		logic [DIST_W-1:0] distance;
		logic [ID_W-1:0]   tag_id;
		logic              found;
	} match_t;

	code_t            code_table [DEPTH];
	logic [MH_W-1:0]  max_hamming  = MAX_HAMMING_RST;
	logic [CIU_W-1:0] codes_in_use = CODES_IN_USE_RST;
	match_t           expected_matches [$];

	// Quarter turn clockwise, gathered per destination cell
	function automatic code_t quarter_turn(input code_t v);
		code_t r;
		for (int dst = 0; dst < CODE_W; dst++) begin
			r[dst] = v[(GRID_SIDE - 1 - dst % GRID_SIDE) * GRID_SIDE + dst / GRID_SIDE];
		end
		return r;
	endfunction

	// Search the used entries for each turn of the grid; first turn within bound wins
	function automatic match_t nearest_match(input code_t raw);
		match_t      res;
		code_t       probe;
		int unsigned span, best, best_idx, ham;
		res   = '0;
		probe = raw;
		span  = (codes_in_use > DEPTH) ? DEPTH : codes_in_use;
		for (int turn = 0; turn < ROT_N; turn++) begin
			best     = max_hamming + 1;
			best_idx = 0;
			for (int i = 0; i < span; i++) begin
				ham = $countones(probe ^ code_table[i]);
				if (ham < best) begin
					best     = ham;
					best_idx = i;
				end
			end
			if (best <= max_hamming) begin
				res.found    = 1'b1;
				res.tag_id   = best_idx[ID_W-1:0];
				res.distance = best[DIST_W-1:0];
				res.rotation = turn[ROT_W-1:0];
				return res;
			end
			probe = quarter_turn(probe);
		end
		return res;
	endfunction

	task automatic report_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// Track registers and table, predict queries, compare results
	always @(posedge clk or negedge arst_n) begin : monitor
		match_t want;
		match_t got;
		if (!arst_n) begin
			max_hamming  = MAX_HAMMING_RST;
			codes_in_use = CODES_IN_USE_RST;
			expected_matches.delete();
			pending    = 0;
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MAX_HAMMING:  max_hamming  = cfg_data[MH_W-1:0];
					REG_CODES_IN_USE: codes_in_use = cfg_data[CIU_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = match_t'(m_tdata[$bits(match_t)-1:0]);
				if (expected_matches.size() == 0) begin
					fail_count++;
					$display("%0t: result item with nothing expected, actual %h",
						$time, m_tdata);
				end else begin
					want = expected_matches.pop_front();
					report_field("found", want.found, got.found);
					report_field("tag_id", want.tag_id, got.tag_id);
					report_field("distance", want.distance, got.distance);
					report_field("rotation", want.rotation, got.rotation);
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == MODE_QUERY) begin
					expected_matches.push_back(nearest_match(s_tdata[CODE_W+ID_W-1:ID_W]));
				end else begin
					code_table[s_tdata[ID_W-1:0]] = s_tdata[CODE_W+ID_W-1:ID_W];
				end
			end
			pending = expected_matches.size();
		end
	end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the rotated code nearest-match block: fills the low part of the code
// table, runs directed queries over ties, all four turns, empty searches and
// threshold extremes, then random loads and queries (mostly noisy turned copies
// of stored codes) under several register settings and idling patterns. The
// match_checker instance predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import rcnm_pkg::*;

	localparam int   DEPTH       = TABLE_DEPTH_DEF;
	localparam int   FILL        = 64;
	localparam int   SEG_ITEMS   = 21;
	localparam int   QUIET_LIMIT = 6000;
	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;
	localparam code_t ALL_ONES   = '1;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [47:0]           s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [23:0]           m_tdata;

	int          fail_count;
	int          pending;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          quiet_cycles;
	int unsigned cur_mh;
	int unsigned cur_ciu;
	code_t       loaded [DEPTH];
	int          idle_plan [4][2] = '{'{0, 0}, '{72, 0}, '{0, 72}, '{20, 20}};

	rotated_code_nearest_match dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	match_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Stall the result side at random
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// End the run when no channel moves an item for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL rotated_code_nearest_match");
			$finish;
		end
	end

	function automatic code_t rand_code();
		return code_t'({$urandom(), $urandom()});
	endfunction

	// Offer one item after a random gap, hold it until accepted
	task automatic send_item(input logic mode, input logic [ID_W-1:0] idx, input code_t code);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {2'b00, code, idx};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (mode == MODE_LOAD) begin
			loaded[idx] = code;
		end
	endtask

	// Drop valid and wait for every outstanding result plus a short margin
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic configure(input int unsigned mh, input int unsigned ciu);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= REG_MAX_HAMMING;
		cfg_data  <= CFG_DATA_W'(mh);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_index <= REG_CODES_IN_USE;
		cfg_data  <= CFG_DATA_W'(ciu);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_mh  = mh & 63;
		cur_ciu = ciu;
	endtask

	// Load, noisy turned copy of a searched entry, or a raw noise query
	task automatic random_item();
		int unsigned span, roll, pick, flips, bound, bitpos;
		code_t       word;
		span = (cur_ciu > DEPTH) ? DEPTH : cur_ciu;
		roll = $urandom_range(99);
		if (roll < 30) begin
			pick = (span > 0 && $urandom_range(1)) ? $urandom_range(span - 1) : $urandom_range(DEPTH - 1);
			if ($urandom_range(3) == 0) begin
				// copy a searched entry to provoke ties
				word = loaded[(span > 0) ? $urandom_range(span - 1) : 0];
			end else begin
				word = rand_code();
			end
			send_item(MODE_LOAD, pick[ID_W-1:0], word);
		end else if (roll < 80 && span > 0) begin
			word = loaded[$urandom_range(span - 1)];
			repeat ($urandom_range(3)) word = turn_cw(word);
			bound = (cur_mh < 5) ? cur_mh + 1 : 6;
			flips = $urandom_range(bound);
			repeat (flips) begin
				bitpos = $urandom_range(CODE_W - 1);
				word[bitpos] = ~word[bitpos];
			end
			send_item(MODE_QUERY, ID_W'($urandom()), word);
		end else begin
			case ($urandom_range(7))
				0:       word = '0;
				1:       word = ALL_ONES;
				default: word = rand_code();
			endcase
			send_item(MODE_QUERY, ID_W'($urandom()), word);
		end
	endtask

	initial begin : stimulus
		int unsigned mh, ciu;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tuser        = MODE_LOAD;
		s_tdata        = '0;
		cfg_valid      = 1'b0;
		cfg_index      = REG_MAX_HAMMING;
		cfg_data       = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		quiet_cycles   = 0;
		cur_mh         = MAX_HAMMING_RST;
		cur_ciu        = CODES_IN_USE_RST;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty table after reset: nothing can match
		send_item(MODE_QUERY, '1, ALL_ONES);
		send_item(MODE_QUERY, '0, '0);

		// Fill every searched entry; low entries get hand-picked codes
		for (int i = 0; i < FILL; i++) begin
			case (i)
				0:       send_item(MODE_LOAD, ID_W'(i), '0);
				1, 2:    send_item(MODE_LOAD, ID_W'(i), ALL_ONES);
				3:       send_item(MODE_LOAD, ID_W'(i), code_t'(1));
				default: send_item(MODE_LOAD, ID_W'(i), rand_code());
			endcase
		end

		// Exact hits, tie to lowest index, one corner cell under each turn
		configure(0, 4);
		send_item(MODE_QUERY, '0, '0);
		send_item(MODE_QUERY, '0, ALL_ONES);
		send_item(MODE_QUERY, '0, code_t'(1));
		send_item(MODE_QUERY, '0, code_t'(1) << 30);
		send_item(MODE_QUERY, '0, code_t'(1) << 35);
		send_item(MODE_QUERY, '0, code_t'(1) << 5);
		send_item(MODE_QUERY, '0, code_t'(3));
		configure(1, 4);
		send_item(MODE_QUERY, '0, code_t'(3));
		// Widest distance, threshold above the code width, all filled entries, empty table
		configure(36, 1);
		send_item(MODE_QUERY, '0, ALL_ONES);
		configure(63, FILL);
		send_item(MODE_QUERY, '1, rand_code());
		configure(36, FILL);
		send_item(MODE_QUERY, '0, rand_code());
		configure(0, 0);
		send_item(MODE_QUERY, '0, '0);

		// Random part under each idling pattern and several settings
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			send_idle_pct  = idle_plan[ph][0];
			recv_stall_pct = idle_plan[ph][1];
			for (int seg = 0; seg < 6; seg++) begin
				case (seg)
					0: begin mh = $urandom_range(3);      ciu = $urandom_range(1, 16); end
					1: begin mh = $urandom_range(2, 8);   ciu = $urandom_range(8, FILL); end
					2: begin mh = 0;                      ciu = $urandom_range(1, FILL); end
					3: begin mh = $urandom_range(36);     ciu = $urandom_range(1, 32); end
					4: begin mh = $urandom_range(1, 6);   ciu = $urandom_range(33, FILL); end
					default: begin mh = $urandom_range(30, 63); ciu = $urandom_range(8); end
				endcase
				configure(mh, ciu);
				repeat (SEG_ITEMS) random_item();
			end
		end

		// Drain and give the verdict
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0) begin
			$display("PASS rotated_code_nearest_match");
		end else begin
			$display("FAIL rotated_code_nearest_match");
		end
		$finish;
	end

endmodule

@@ rotated_code_nearest_match.f @@
rtl/core/rcnm_pkg.sv
rtl/core/rcnm_ram.sv
rtl/core/rotated_code_nearest_match.sv
rtl/core/rcnm_checker.sv
bench/match_checker.sv
bench/testbench.sv
